// ===== design/ogbt_pkg.sv =====
`timescale 1ns / 1ps

package ogbt_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int MaxBlock  = 64;

  localparam int PixW     = 8;
  localparam int DimW     = 13;
  localparam int BlkW     = 7;
  localparam int LvlW     = 9;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int InCellW  = $clog2(MaxBlock);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  localparam int OutDepth = 3;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 2;

  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;
  localparam logic [BlkW-1:0] BlockReset  = 7'd8;
  localparam logic [LvlW-1:0] LevelReset  = 9'd128;
  localparam logic [PixW-1:0] FreeReset   = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth    = 3'd0,
    CfgImageHeight   = 3'd1,
    CfgBlockSize     = 3'd2,
    CfgOccupiedBelow = 3'd3,
    CfgFreeValue     = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [PixW-1:0] cell_value;
    logic            last_in_row;
    logic            last_of_map;
  } cell_t;

endpackage

// ===== design/ogbt_out_fifo.sv =====
`timescale 1ns / 1ps

module ogbt_out_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ogbt_pkg::cell_t             push_data_i,
  input  logic                        pop_i,
  output ogbt_pkg::cell_t             data_o,
  output logic                        valid_o,
  output logic [ogbt_pkg::OutCntW-1:0] count_o
);

  localparam logic [ogbt_pkg::OutPtrW-1:0] LastPtr =
    ogbt_pkg::OutPtrW'(ogbt_pkg::OutDepth - 1);

  ogbt_pkg::cell_t entries_q [ogbt_pkg::OutDepth];

  logic [ogbt_pkg::OutPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ogbt_pkg::OutPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ogbt_pkg::OutCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o  = entries_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

// ===== design/occupancy_grid_block_threshold.sv =====
// after its last pixel, a cell passes the second stage and the output queue to m_axis
// throughput: one pixel per cycle if the queue has room; the per-column flag memory
//   does one read and one write per cycle, back-to-back read-modify-writes forwarded
// a three-entry output queue absorbs stalls on m_axis without losing a pixel
// reset: configuration returns to 640x480, block 8, level 128, free 255, position
//   counters clear; the flag memory is not cleared, every cell writes it first
`timescale 1ns / 1ps

module occupancy_grid_block_threshold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream: tdata = pixel[7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // master stream: tdata = cell_value[7:0], tlast = last_in_row, tuser = last_of_map
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ogbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ogbt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int DimW    = ogbt_pkg::DimW;
  localparam int BlkW    = ogbt_pkg::BlkW;
  localparam int ColW    = ogbt_pkg::ColW;
  localparam int RowW    = ogbt_pkg::RowW;
  localparam int InCellW = ogbt_pkg::InCellW;
  localparam int SumW    = DimW + 1;

  // configuration
  logic [DimW-1:0]           img_w_q, img_h_q;
  logic [BlkW-1:0]           blk_q;
  logic [ogbt_pkg::LvlW-1:0] level_q;
  logic [ogbt_pkg::PixW-1:0] free_q;

  // position
  logic [ColW-1:0]    pix_col_q, pix_col_d;
  logic [RowW-1:0]    pix_row_q, pix_row_d;
  logic [InCellW-1:0] col_in_cell_q, col_in_cell_d;
  logic [InCellW-1:0] row_in_cell_q, row_in_cell_d;
  logic [ColW-1:0]    cell_col_q, cell_col_d;
  logic [ColW-1:0]    col_start_q, col_start_d;
  logic [RowW-1:0]    row_start_q, row_start_d;

  // flag memory
  logic flag_mem [ogbt_pkg::MaxWidth];
  logic rd_flag_q;

  // second stage
  logic            s1_valid_q;
  logic            s1_inrange_q, s1_first_q, s1_hit_q, s1_last_q;
  logic            s1_end_row_q, s1_end_map_q;
  logic [ColW-1:0] s1_addr_q;
  logic            fwd_q, fwd_flag_q;
  logic            s1_flag;
  logic            s1_emit;

  logic [DimW-1:0] w_c, h_c;
  logic [BlkW-1:0] bs_c, bs_m1;
  logic            in_xfer, cfg_xfer, out_xfer;
  logic            col_fit, row_fit, inrange, first_px, last_px, hit;
  logic            end_row, end_map;
  logic [DimW-1:0] pix_col_inc, pix_row_inc;
  logic [BlkW-1:0] col_cell_inc, row_cell_inc;

  ogbt_pkg::cell_t                push_cell, head_cell;
  logic [ogbt_pkg::OutCntW-1:0]   fifo_cnt;
  logic                           fifo_valid;
  logic [ogbt_pkg::OutCntW:0]     pending;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ogbt_pkg::WidthReset;
      img_h_q <= ogbt_pkg::HeightReset;
      blk_q   <= ogbt_pkg::BlockReset;
      level_q <= ogbt_pkg::LevelReset;
      free_q  <= ogbt_pkg::FreeReset;
    end else if (cfg_xfer) begin
      unique case (ogbt_pkg::cfg_index_e'(cfg_index_i))
        ogbt_pkg::CfgImageWidth:    img_w_q <= cfg_data_i[DimW-1:0];
        ogbt_pkg::CfgImageHeight:   img_h_q <= cfg_data_i[DimW-1:0];
        ogbt_pkg::CfgBlockSize:     blk_q   <= cfg_data_i[BlkW-1:0];
        ogbt_pkg::CfgOccupiedBelow: level_q <= cfg_data_i[ogbt_pkg::LvlW-1:0];
        ogbt_pkg::CfgFreeValue:     free_q  <= cfg_data_i[ogbt_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (img_w_q == '0) begin
      w_c = DimW'(1);
    end else if (img_w_q > DimW'(ogbt_pkg::MaxWidth)) begin
      w_c = DimW'(ogbt_pkg::MaxWidth);
    end else begin
      w_c = img_w_q;
    end
    if (img_h_q == '0) begin
      h_c = DimW'(1);
    end else if (img_h_q > DimW'(ogbt_pkg::MaxHeight)) begin
      h_c = DimW'(ogbt_pkg::MaxHeight);
    end else begin
      h_c = img_h_q;
    end
    if (blk_q == '0) begin
      bs_c = BlkW'(1);
    end else if (blk_q > BlkW'(ogbt_pkg::MaxBlock)) begin
      bs_c = BlkW'(ogbt_pkg::MaxBlock);
    end else begin
      bs_c = blk_q;
    end
  end

  assign bs_m1 = bs_c - 1'b1;

  // current cell lies fully inside the image
  assign col_fit  = (SumW'(col_start_q) + SumW'(bs_c)) <= SumW'(w_c);
  assign row_fit  = (SumW'(row_start_q) + SumW'(bs_c)) <= SumW'(h_c);
  assign inrange  = col_fit & row_fit;
  assign end_row  = (SumW'(col_start_q) + SumW'({bs_c, 1'b0})) > SumW'(w_c);
  assign end_map  = end_row & ((SumW'(row_start_q) + SumW'({bs_c, 1'b0})) > SumW'(h_c));
  assign first_px = (col_in_cell_q == '0) & (row_in_cell_q == '0);
  assign last_px  = (BlkW'(col_in_cell_q) == bs_m1) & (BlkW'(row_in_cell_q) == bs_m1);
  assign hit      = {1'b0, s_axis_tdata} < level_q;

  assign pending       = (ogbt_pkg::OutCntW + 1)'(fifo_cnt) +
                         (ogbt_pkg::OutCntW + 1)'(s1_valid_q);
  assign s_axis_tready = pending < (ogbt_pkg::OutCntW + 1)'(ogbt_pkg::OutDepth);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  assign pix_col_inc  = DimW'(pix_col_q) + 1'b1;
  assign pix_row_inc  = DimW'(pix_row_q) + 1'b1;
  assign col_cell_inc = BlkW'(col_in_cell_q) + 1'b1;
  assign row_cell_inc = BlkW'(row_in_cell_q) + 1'b1;

  always_comb begin
    pix_col_d     = pix_col_q;
    pix_row_d     = pix_row_q;
    col_in_cell_d = col_in_cell_q;
    row_in_cell_d = row_in_cell_q;
    cell_col_d    = cell_col_q;
    col_start_d   = col_start_q;
    row_start_d   = row_start_q;
    if (pix_col_inc >= w_c) begin
      pix_col_d     = '0;
      col_in_cell_d = '0;
      cell_col_d    = '0;
      col_start_d   = '0;
      if (pix_row_inc >= h_c) begin
        pix_row_d     = '0;
        row_in_cell_d = '0;
        row_start_d   = '0;
      end else begin
        pix_row_d = pix_row_inc[RowW-1:0];
        if (row_cell_inc >= bs_c) begin
          row_in_cell_d = '0;
          row_start_d   = pix_row_inc[RowW-1:0];
        end else begin
          row_in_cell_d = row_cell_inc[InCellW-1:0];
        end
      end
    end else begin
      pix_col_d = pix_col_inc[ColW-1:0];
      if (col_cell_inc >= bs_c) begin
        col_in_cell_d = '0;
        cell_col_d    = cell_col_q + 1'b1;
        col_start_d   = pix_col_inc[ColW-1:0];
      end else begin
        col_in_cell_d = col_cell_inc[InCellW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q     <= '0;
      pix_row_q     <= '0;
      col_in_cell_q <= '0;
      row_in_cell_q <= '0;
      cell_col_q    <= '0;
      col_start_q   <= '0;
      row_start_q   <= '0;
    end else if (cfg_xfer) begin
      pix_col_q     <= '0;
      pix_row_q     <= '0;
      col_in_cell_q <= '0;
      row_in_cell_q <= '0;
      cell_col_q    <= '0;
      col_start_q   <= '0;
      row_start_q   <= '0;
    end else if (in_xfer) begin
      pix_col_q     <= pix_col_d;
      pix_row_q     <= pix_row_d;
      col_in_cell_q <= col_in_cell_d;
      row_in_cell_q <= row_in_cell_d;
      cell_col_q    <= cell_col_d;
      col_start_q   <= col_start_d;
      row_start_q   <= row_start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
    end
  end

  // stage payload, forward when the previous pixel writes the same column
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_inrange_q <= inrange;
      s1_first_q   <= first_px;
      s1_hit_q     <= hit;
      s1_last_q    <= last_px;
      s1_end_row_q <= end_row;
      s1_end_map_q <= end_map;
      s1_addr_q    <= cell_col_q;
      fwd_q        <= s1_valid_q & s1_inrange_q & (s1_addr_q == cell_col_q);
      fwd_flag_q   <= s1_flag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_flag_q <= flag_mem[cell_col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_inrange_q) begin
      flag_mem[s1_addr_q] <= s1_flag;
    end
  end

  assign s1_flag = s1_first_q ? s1_hit_q : ((fwd_q ? fwd_flag_q : rd_flag_q) | s1_hit_q);
  assign s1_emit = s1_valid_q & s1_inrange_q & s1_last_q;

  assign push_cell.cell_value  = s1_flag ? '0 : free_q;
  assign push_cell.last_in_row = s1_end_row_q;
  assign push_cell.last_of_map = s1_end_map_q;

  assign out_xfer = m_axis_tvalid & m_axis_tready;

  ogbt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_emit),
    .push_data_i (push_cell),
    .pop_i       (out_xfer),
    .data_o      (head_cell),
    .valid_o     (fifo_valid),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = head_cell.cell_value;
  assign m_axis_tlast  = head_cell.last_in_row;
  assign m_axis_tuser  = head_cell.last_of_map;

`ifndef SYNTHESIS
  a_room_for_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit |-> (fifo_cnt != ogbt_pkg::OutCntW'(ogbt_pkg::OutDepth)))
    else $error("cell pushed into full output queue");

  a_map_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit && s1_end_map_q |-> s1_end_row_q)
    else $error("end of map without end of row");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer |=> (pix_col_q == '0) && (pix_row_q == '0) && (cell_col_q == '0))
    else $error("configuration write did not restart the frame");

  a_in_cell_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (BlkW'(col_in_cell_q) < bs_c) && (BlkW'(row_in_cell_q) < bs_c))
    else $error("position inside cell out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [ogbt_pkg::CfgIdxW-1:0] CfgUnusedLo = 3'd5;
  localparam logic [ogbt_pkg::CfgIdxW-1:0] CfgUnusedHi = 3'd7;
  localparam int HoldCycles = 300;
  localparam int unsigned ItemCount = 1400;

  // tracks the grid position and cell flags, holds the cells still owed by the block
  class grid_tracker;
    bit [ogbt_pkg::DimW-1:0] img_w, img_h;
    bit [ogbt_pkg::BlkW-1:0] blk;
    bit [ogbt_pkg::LvlW-1:0] level;
    bit [ogbt_pkg::PixW-1:0] free_val;
    int unsigned             col, row, col_in, row_in, cell_col;
    bit                      occ [ogbt_pkg::MaxWidth];
    ogbt_pkg::cell_t         cells_due[$];
    int unsigned             failures;

    function new();
      img_w    = ogbt_pkg::WidthReset;
      img_h    = ogbt_pkg::HeightReset;
      blk      = ogbt_pkg::BlockReset;
      level    = ogbt_pkg::LevelReset;
      free_val = ogbt_pkg::FreeReset;
      failures = 0;
      restart();
    endfunction

    function void restart();
      col      = 0;
      row      = 0;
      col_in   = 0;
      row_in   = 0;
      cell_col = 0;
    endfunction

    function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clampu(32'(img_w), 1, ogbt_pkg::MaxWidth) *
             clampu(32'(img_h), 1, ogbt_pkg::MaxHeight);
    endfunction

    function void set_register(logic [ogbt_pkg::CfgIdxW-1:0] idx,
                               logic [ogbt_pkg::CfgDataW-1:0] data);
      case (idx)
        ogbt_pkg::CfgImageWidth:    img_w    = data;
        ogbt_pkg::CfgImageHeight:   img_h    = data;
        ogbt_pkg::CfgBlockSize:     blk      = data[ogbt_pkg::BlkW-1:0];
        ogbt_pkg::CfgOccupiedBelow: level    = data[ogbt_pkg::LvlW-1:0];
        ogbt_pkg::CfgFreeValue:     free_val = data[ogbt_pkg::PixW-1:0];
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [ogbt_pkg::PixW-1:0] px);
      int unsigned w, h, bs, cols, rows;
      bit hit, flag;
      ogbt_pkg::cell_t c;
      w    = clampu(32'(img_w), 1, ogbt_pkg::MaxWidth);
      h    = clampu(32'(img_h), 1, ogbt_pkg::MaxHeight);
      bs   = clampu(32'(blk), 1, ogbt_pkg::MaxBlock);
      cols = w / bs;
      rows = h / bs;
      if (col < cols * bs && row < rows * bs && cell_col < cols) begin
        hit  = px < level;
        flag = (row_in == 0 && col_in == 0) ? hit : (occ[cell_col] | hit);
        occ[cell_col] = flag;
        if (row_in == bs - 1 && col_in == bs - 1) begin
          c.cell_value  = flag ? '0 : free_val;
          c.last_in_row = (cell_col == cols - 1);
          c.last_of_map = c.last_in_row && (row == rows * bs - 1);
          cells_due = {cells_due, c};
        end
      end
      if (col + 1 >= w) begin
        col      = 0;
        col_in   = 0;
        cell_col = 0;
        if (row + 1 >= h) begin
          row    = 0;
          row_in = 0;
        end else begin
          row++;
          row_in = (row_in + 1 >= bs) ? 0 : row_in + 1;
        end
      end else begin
        col++;
        if (col_in + 1 >= bs) begin
          col_in = 0;
          cell_col++;
        end else begin
          col_in++;
        end
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_cell(ogbt_pkg::cell_t got);
      ogbt_pkg::cell_t want;
      if (cells_due.size() == 0) begin
        $display("%0t ns: unexpected cell, expected none, actual value %0d tlast %0b tuser %0b",
                 $time, got.cell_value, got.last_in_row, got.last_of_map);
        failures++;
      end else begin
        want = cells_due.pop_front();
        compare_field("cell_value", want.cell_value, got.cell_value);
        compare_field("last_in_row", 8'(want.last_in_row), 8'(got.last_in_row));
        compare_field("last_of_map", 8'(want.last_of_map), 8'(got.last_of_map));
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ogbt_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ogbt_pkg::CfgDataW-1:0] cfg_data_i;

  grid_tracker tracker = new();
  int unsigned burst_left;
  bit          hold_req;
  int unsigned rx_cycle;
  int unsigned pixels_sent;

  occupancy_grid_block_threshold i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: own stall pattern, long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    rx_cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      rx_cycle++;
      case ((rx_cycle / 97) % 4)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = (rx_cycle % 5 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_cell(ogbt_pkg::cell_t'({m_axis_tdata, m_axis_tlast, m_axis_tuser}));
    end
  end

  function automatic logic [7:0] pick_pixel(int unsigned pct);
    int unsigned lvl;
    lvl = 32'(tracker.level);
    if ($urandom_range(0, 99) < pct && lvl > 0) begin
      return (lvl > 255) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, lvl - 1));
    end
    return (lvl <= 255) ? 8'($urandom_range(lvl, 255)) : 8'($urandom_range(0, 255));
  endfunction

  // called and returns at a falling edge, tvalid left high for the next transfer
  task automatic send_pixel(input logic [7:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    s_axis_tdata  = px;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_pixel(px);
    pixels_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned count, input int unsigned pct);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(pct));
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (tracker.cells_due.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ogbt_pkg::CfgIdxW-1:0] idx,
                           input logic [ogbt_pkg::CfgDataW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned low_pcts[6] = '{0, 1, 2, 5, 20, 60};
    int unsigned frame, n, r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    burst_left    = 0;
    pixels_sent   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset block, level and free value: two cell rows of a 16 wide image
    write_reg(ogbt_pkg::CfgImageWidth, 13'd16);
    send_pixels(16 * 16, 1);
    drain();

    // zero dimensions clamp to one pixel per cell
    write_reg(ogbt_pkg::CfgImageWidth, 13'd0);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd0);
    write_reg(ogbt_pkg::CfgBlockSize, 13'd0);
    send_pixel(8'd0);
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain();
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd256);
    send_pixel(8'd255);
    drain();
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd511);
    write_reg(ogbt_pkg::CfgFreeValue, 13'd0);
    send_pixel(8'd255);
    drain();
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd1);
    write_reg(ogbt_pkg::CfgFreeValue, 13'hA5);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'h5A);
    drain();

    // long receiver hold-off while pixels keep coming
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd200);
    hold_req = 1'b1;
    send_pixels(60, 50);
    drain();

    // wide row, width above the maximum clamps
    write_reg(ogbt_pkg::CfgImageWidth, 13'd8191);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd1);
    write_reg(ogbt_pkg::CfgBlockSize, 13'd1);
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd128);
    write_reg(ogbt_pkg::CfgFreeValue, 13'd255);
    send_pixels(200, 50);
    drain();

    // tall column
    write_reg(ogbt_pkg::CfgImageWidth, 13'd1);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd4096);
    send_pixels(150, 50);
    drain();

    // oversized block size clamps
    write_reg(ogbt_pkg::CfgImageWidth, 13'd64);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd64);
    write_reg(ogbt_pkg::CfgBlockSize, 13'd127);
    write_reg(ogbt_pkg::CfgOccupiedBelow, 13'd100);
    send_pixels(100, 50);
    drain();

    // block larger than the image gives no cells
    write_reg(ogbt_pkg::CfgImageWidth, 13'd5);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd5);
    write_reg(ogbt_pkg::CfgBlockSize, 13'd8);
    send_pixels(30, 50);
    drain();

    // writes to unused indexes restart the frame
    write_reg(ogbt_pkg::CfgImageWidth, 13'd4);
    write_reg(ogbt_pkg::CfgImageHeight, 13'd4);
    write_reg(ogbt_pkg::CfgBlockSize, 13'd2);
    send_pixels(6, 20);
    drain();
    write_reg(CfgUnusedLo, 13'($urandom_range(0, 8191)));
    send_pixels(16, 20);
    send_pixels(3, 20);
    drain();
    write_reg(CfgUnusedHi, 13'($urandom_range(0, 8191)));
    send_pixels(16, 20);
    drain();

    while (pixels_sent < ItemCount) begin
      drain();
      if ($urandom_range(0, 3) != 0) begin
        write_reg(ogbt_pkg::CfgImageWidth,
                  13'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 20)));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(ogbt_pkg::CfgImageHeight,
                  13'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 20)));
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        write_reg(ogbt_pkg::CfgBlockSize,
                  13'((r == 0) ? 0 : (r == 1) ? $urandom_range(7, 127)
                                              : $urandom_range(1, 5)));
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        write_reg(ogbt_pkg::CfgOccupiedBelow,
                  13'((r == 0) ? 0 : (r == 1) ? $urandom_range(256, 511)
                                              : $urandom_range(1, 255)));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(ogbt_pkg::CfgFreeValue, 13'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(3'($urandom_range(CfgUnusedLo, CfgUnusedHi)),
                  13'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 9) == 0) hold_req = 1'b1;
      frame = tracker.frame_pixels();
      // mostly whole frames, sometimes a frame cut short
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame)
                                      : frame * $urandom_range(1, 3);
      if (n > ItemCount - pixels_sent) n = ItemCount - pixels_sent;
      send_pixels(n, low_pcts[$urandom_range(0, 5)]);
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (tracker.failures == 0 && tracker.cells_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== occupancy_grid_block_threshold.f =====
design/ogbt_pkg.sv
design/ogbt_out_fifo.sv
design/occupancy_grid_block_threshold.sv
verif/testbench.sv
